>>> src/xtea_pkg.sv
// Shared types, constants and helper functions for the XTEA block cipher.
// No dependencies; every other file in src refers to this package by scope.
package xtea_pkg;

    localparam int BLOCK_W   = 64;
    localparam int HALF_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [HALF_W-1:0] XTEA_DELTA = 32'h9E37_79B9;
    localparam logic [HALF_W-1:0] MIX_MASK   = 32'h07FF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HIGH     = 2'd0,
        CFG_KEY_LOW      = 2'd1,
        CFG_ENCRYPT_MODE = 2'd2
    } cfg_index_t;

    // Broadcast from the top level to every round stage
    typedef struct packed {
        logic advance;
        logic encrypt;
    } stage_ctl_t;

    function automatic logic [HALF_W-1:0] mix(input logic [HALF_W-1:0] v);
        mix = ((v << 4) ^ ((v >> 5) & MIX_MASK)) + v;
    endfunction

    function automatic logic [HALF_W-1:0] key_word(input logic [CFG_W-1:0] key_high,
                                                   input logic [CFG_W-1:0] key_low,
                                                   input logic [1:0]       sel);
        case (sel)
            2'd0:    key_word = key_high[63:32];
            2'd1:    key_word = key_high[31:0];
            2'd2:    key_word = key_low[63:32];
            default: key_word = key_low[31:0];
        endcase
    endfunction

endpackage

>>> src/xtea_stream_if.sv
// Valid/ready stream interfaces for the XTEA block cipher's input and output.
// Depends on xtea_pkg for the block width.
interface xtea_in_if;
    logic                          valid;
    logic                          ready;
    logic [xtea_pkg::BLOCK_W-1:0]  in_block;

    modport source (output valid, output in_block, input ready);
    modport sink   (input valid, input in_block, output ready);
endinterface

interface xtea_out_if;
    logic                          valid;
    logic                          ready;
    logic [xtea_pkg::BLOCK_W-1:0]  out_block;

    modport source (output valid, output out_block, input ready);
    modport sink   (input valid, input out_block, output ready);
endinterface

>>> src/xtea_block_cipher.sv
// Top level of the XTEA block cipher: configuration registers, the unrolled
// half-round pipeline and the output buffer. Depends on xtea_pkg,
// xtea_stream_if, xtea_half_round and xtea_out_buf.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-------------------------------
//  blk_in    | in  | valid/ready        | in_block  [63:0] plaintext or ciphertext
//  blk_out   | out | valid/ready        | out_block [63:0] result
//  cfg       | in  | cfg_we, no ready   | cfg_index [1:0], cfg_data [63:0]
//
// One block is accepted per cycle while the output buffer has room; there is
// one register stage per half round plus the output buffer.
// Reset clears the pipeline valids and the buffer, keys to zero, mode encrypt.
// A stalled sink fills the two-entry buffer; the pipeline then holds as a
// whole and blk_in.ready drops, with no transaction lost or repeated.
module xtea_block_cipher #(
    parameter int ROUND_COUNT = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    xtea_in_if.sink                         blk_in,
    xtea_out_if.source                      blk_out,
    input  logic                            cfg_we,
    input  logic [xtea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [xtea_pkg::CFG_W-1:0]      cfg_data
);

    localparam int NSTAGE = 2 * ROUND_COUNT;

    logic [xtea_pkg::CFG_W-1:0]   key_high_reg;
    logic [xtea_pkg::CFG_W-1:0]   key_low_reg;
    logic                         encrypt_reg;

    xtea_pkg::stage_ctl_t         ctl;
    logic                         room;
    logic [NSTAGE:0]              vld;
    logic [xtea_pkg::HALF_W-1:0]  v0 [NSTAGE+1];
    logic [xtea_pkg::HALF_W-1:0]  v1 [NSTAGE+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            encrypt_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                xtea_pkg::CFG_KEY_HIGH:     key_high_reg <= cfg_data;
                xtea_pkg::CFG_KEY_LOW:      key_low_reg  <= cfg_data;
                xtea_pkg::CFG_ENCRYPT_MODE: encrypt_reg  <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    assign ctl.advance  = room;
    assign ctl.encrypt  = encrypt_reg;
    assign blk_in.ready = room;

    assign vld[0] = blk_in.valid;
    assign v0[0]  = blk_in.in_block[63:32];
    assign v1[0]  = blk_in.in_block[31:0];

    // Stage s uses running sum k*delta when encrypting and
    // (ROUND_COUNT-k)*delta when decrypting, with k = (s+1)/2
    for (genvar s = 0; s < NSTAGE; s++)
    begin : g_stage
        localparam int          K        = (s + 1) / 2;
        localparam logic [63:0] PROD_ENC = 64'(K) * 64'(xtea_pkg::XTEA_DELTA);
        localparam logic [63:0] PROD_DEC = 64'(ROUND_COUNT - K)
                                           * 64'(xtea_pkg::XTEA_DELTA);
        localparam logic [31:0] S_ENC    = PROD_ENC[31:0];
        localparam logic [31:0] S_DEC    = PROD_DEC[31:0];
        localparam bit          EVEN     = ((s % 2) == 0);

        xtea_half_round #(
            .SUM_ENC    (S_ENC),
            .SUM_DEC    (S_DEC),
            .KEY_ENC    (EVEN ? S_ENC[1:0] : S_ENC[12:11]),
            .KEY_DEC    (EVEN ? S_DEC[12:11] : S_DEC[1:0]),
            .UPD_V0_ENC (EVEN)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .key_high  (key_high_reg),
            .key_low   (key_low_reg),
            .valid_in  (vld[s]),
            .v0_in     (v0[s]),
            .v1_in     (v1[s]),
            .valid_out (vld[s+1]),
            .v0_out    (v0[s+1]),
            .v1_out    (v1[s+1])
        );
    end

    xtea_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (vld[NSTAGE]),
        .pipe_data  ({v0[NSTAGE], v1[NSTAGE]}),
        .room       (room),
        .blk_out    (blk_out)
    );

endmodule

>>> src/xtea_half_round.sv
// One XTEA half round as a single pipeline register stage.
// Depends on xtea_pkg (mix, key_word, stage_ctl_t).
module xtea_half_round #(
    parameter logic [31:0] SUM_ENC    = 32'h0,
    parameter logic [31:0] SUM_DEC    = 32'h0,
    parameter logic [1:0]  KEY_ENC    = 2'd0,
    parameter logic [1:0]  KEY_DEC    = 2'd0,
    parameter bit          UPD_V0_ENC = 1'b1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  xtea_pkg::stage_ctl_t         ctl,
    input  logic [xtea_pkg::CFG_W-1:0]   key_high,
    input  logic [xtea_pkg::CFG_W-1:0]   key_low,
    input  logic                         valid_in,
    input  logic [xtea_pkg::HALF_W-1:0]  v0_in,
    input  logic [xtea_pkg::HALF_W-1:0]  v1_in,
    output logic                         valid_out,
    output logic [xtea_pkg::HALF_W-1:0]  v0_out,
    output logic [xtea_pkg::HALF_W-1:0]  v1_out
);

    logic                         valid_reg;
    logic [xtea_pkg::HALF_W-1:0]  v0_reg;
    logic [xtea_pkg::HALF_W-1:0]  v1_reg;
    logic [xtea_pkg::HALF_W-1:0]  v0_next;
    logic [xtea_pkg::HALF_W-1:0]  v1_next;

    logic                         upd_v0;
    logic [xtea_pkg::HALF_W-1:0]  sum;
    logic [1:0]                   key_sel;
    logic [xtea_pkg::HALF_W-1:0]  src;
    logic [xtea_pkg::HALF_W-1:0]  dst;
    logic [xtea_pkg::HALF_W-1:0]  delta_term;
    logic [xtea_pkg::HALF_W-1:0]  new_half;

    // Decryption walks the rounds backwards, so the updated half swaps
    always_comb
    begin
        upd_v0     = ctl.encrypt ? UPD_V0_ENC : !UPD_V0_ENC;
        sum        = ctl.encrypt ? SUM_ENC : SUM_DEC;
        key_sel    = ctl.encrypt ? KEY_ENC : KEY_DEC;
        src        = upd_v0 ? v1_in : v0_in;
        dst        = upd_v0 ? v0_in : v1_in;
        delta_term = xtea_pkg::mix(src)
                     ^ (sum + xtea_pkg::key_word(key_high, key_low, key_sel));
        new_half   = ctl.encrypt ? dst + delta_term : dst - delta_term;
        v0_next    = upd_v0 ? new_half : v0_in;
        v1_next    = upd_v0 ? v1_in : new_half;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    assign valid_out = valid_reg;
    assign v0_out    = v0_reg;
    assign v1_out    = v1_reg;

endmodule

>>> src/xtea_out_buf.sv
// Two-entry output buffer that decouples the round pipeline from the sink.
// Depends on xtea_pkg and the xtea_out_if interface.
module xtea_out_buf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pipe_valid,
    input  logic [xtea_pkg::BLOCK_W-1:0]  pipe_data,
    output logic                          room,
    xtea_out_if.source                    blk_out
);

    logic [1:0]                    count_reg;
    logic [1:0]                    count_next;
    logic [xtea_pkg::BLOCK_W-1:0]  head_reg;
    logic [xtea_pkg::BLOCK_W-1:0]  head_next;
    logic [xtea_pkg::BLOCK_W-1:0]  tail_reg;
    logic [xtea_pkg::BLOCK_W-1:0]  tail_next;
    logic                          push;
    logic                          pop;

    // Room depends on stored state only, so ready never waits on the sink
    assign room = (count_reg != 2'd2);
    assign push = room && pipe_valid;
    assign pop  = blk_out.valid && blk_out.ready;

    always_comb
    begin
        count_next = 2'(count_reg + {1'b0, push} - {1'b0, pop});
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (pop)
        begin
            if (count_reg == 2'd2)
                head_next = tail_reg;
            else if (push)
                head_next = pipe_data;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                head_next = pipe_data;
            else
                tail_next = pipe_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign blk_out.valid     = (count_reg != 2'd0);
    assign blk_out.out_block = head_reg;

endmodule

>>> src/xtea_checker.sv
// Port-level checks on the XTEA block cipher's flow control.
// Bound to xtea_block_cipher below; depends on xtea_pkg for widths.
module xtea_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [xtea_pkg::BLOCK_W-1:0]  out_block
);

    // A stalled result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_block))
        else $error("stalled out_block changed or was dropped");

    // Input back-pressure only ever comes from a full output buffer
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // The buffer can only fill while the sink refuses a result
    a_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("ready dropped without a stalled result");

    // Space reopens only after a result transaction
    a_drain_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> $past(out_valid && out_ready))
        else $error("ready rose without a result transaction");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (blk_in.valid),
    .in_ready  (blk_in.ready),
    .out_valid (blk_out.valid),
    .out_ready (blk_out.ready),
    .out_block (blk_out.out_block)
);
